// File: sv/rcpb_pkg.sv
// Package for the RTCP compound packet builder: opcodes, status codes, command types.
// No dependencies.
package rcpb_pkg;

   localparam int BUFFER_BYTES_DEF = 1024;
   localparam int QUEUE_DEPTH      = 2;

   typedef enum logic [3:0] {
      OP_RESET    = 4'd0,
      OP_SR       = 4'd1,
      OP_RR       = 4'd2,
      OP_BLOCK    = 4'd3,
      OP_SDES     = 4'd4,
      OP_CHUNK    = 4'd5,
      OP_CNAME    = 4'd6,
      OP_CHUNKEND = 4'd7,
      OP_BYE      = 4'd8,
      OP_BYESSRC  = 4'd9,
      OP_REASON   = 4'd10,
      OP_BYTE     = 4'd11,
      OP_END      = 4'd12,
      OP_READ     = 4'd13,
      OP_NOP14    = 4'd14,
      OP_NOP15    = 4'd15
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_MISALIGN = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_WRITE = 2'd1,
      BK_READ  = 2'd2,
      BK_DONE  = 2'd3
   } back_state_type;

   localparam logic [7:0] HDR_BYTE  = 8'h80;
   localparam logic [7:0] PT_SR     = 8'd200;
   localparam logic [7:0] PT_RR     = 8'd201;
   localparam logic [7:0] PT_SDES   = 8'd202;
   localparam logic [7:0] PT_BYE    = 8'd203;
   localparam logic [7:0] SDES_CNAME = 8'd1;

   // Raw command as taken from the request ports.
   typedef struct packed {
      opcode_type  op;
      logic [31:0] ssrc;
      logic [7:0]  fraction;
      logic [31:0] v1;
      logic [31:0] v2;
      logic [31:0] v3;
      logic [31:0] v4;
      logic [31:0] v5;
      logic [7:0]  text_length;
      logic [7:0]  text_byte;
      logic [9:0]  read_index;
   } cmd_type;

endpackage

// File: sv/rcpb_front.sv
// Front end of the RTCP builder: a short command queue between the request
// ports and the executing back end. Depends on rcpb_pkg.
module rcpb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rcpb_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output rcpb_pkg::cmd_type head_cmd
);
   localparam int D = rcpb_pkg::QUEUE_DEPTH;

   rcpb_pkg::cmd_type slot_ff [D];
   logic [$clog2(D)-1:0] wr_ff, rd_ff;
   logic [$clog2(D):0]   cnt_ff;

   assign full     = (cnt_ff == ($clog2(D)+1)'(D));
   assign empty    = (cnt_ff == '0);
   assign head_cmd = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_cmd;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end
endmodule

// File: sv/rcpb_back.sv
// Back end of the RTCP builder: checks space and count, then writes the
// command's bytes into the message buffer one word per cycle. Depends on rcpb_pkg.
module rcpb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [10:0]       limit,
   input  logic              cmd_valid,
   input  rcpb_pkg::cmd_type cmd,
   output logic              cmd_take,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [10:0]       rsp_message_length,
   output logic [7:0]        rsp_read_data
);
   localparam int BUFFER_BYTES = rcpb_pkg::BUFFER_BYTES_DEF;
   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int PW = AW + 2;   // position width: holds up to 2*BUFFER_BYTES
   localparam int WORDS = BUFFER_BYTES / 4;
   localparam int WW = AW - 2;

   // Word memory with per-byte enables.
   logic [31:0] mem [WORDS];

   logic [PW-1:0] wp_ff, wp_in;
   logic [PW-1:0] ps_ff, ps_in;
   logic [PW-1:0] cs_ff, cs_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [7:0]    trem_ff, trem_in;
   logic [1:0]    rpad_ff, rpad_in;
   logic          trsn_ff, trsn_in;

   rcpb_pkg::back_state_type st_ff, st_in;

   // Byte sequence to emit: up to 28 bytes of data then optional header patch.
   logic [7:0]    seq_ff [28];
   logic [7:0]    seq_in [28];
   logic [4:0]    nb_ff, nb_in;        // bytes in sequence
   logic [4:0]    ix_ff, ix_in;        // next byte to emit
   logic [PW-1:0] base_ff, base_in;    // address of byte 0
   logic          patch_ff, patch_in;  // rewrite a header byte at end
   logic [PW-1:0] paddr_ff, paddr_in;
   logic [7:0]    pdat_ff, pdat_in;
   logic          patch2_ff, patch2_in;
   logic [7:0]    pdat2_ff, pdat2_in;
   logic [1:0]    stat_ff, stat_in;
   logic [9:0]    ridx_ff, ridx_in;
   logic          rd_ok_ff, rd_ok_in;
   logic [7:0]    rdat_ff;

   // Effective limit and free space.
   logic [PW-1:0] lim, space;
   always_comb begin
      lim = (PW'(limit) > PW'(BUFFER_BYTES)) ? PW'(BUFFER_BYTES) : PW'(limit);
      space = (wp_ff <= lim) ? lim - wp_ff : '0;
   end

   // Current word write: bytes of a 4-byte aligned window.
   logic          we;
   logic [WW-1:0] waddr;
   logic [31:0]   wdata;
   logic [3:0]    wbe;

   logic [PW-1:0] cur, chpad_t;
   logic [1:0]    chpad, rspad;
   logic [8:0]    rneed;

   always_comb begin
      wp_in = wp_ff; ps_in = ps_ff; cs_in = cs_ff; cnt_in = cnt_ff;
      trem_in = trem_ff; rpad_in = rpad_ff; trsn_in = trsn_ff;
      st_in = st_ff; nb_in = nb_ff; ix_in = ix_ff; base_in = base_ff;
      patch_in = patch_ff; paddr_in = paddr_ff; pdat_in = pdat_ff;
      patch2_in = patch2_ff; pdat2_in = pdat2_ff;
      stat_in = stat_ff; ridx_in = ridx_ff; rd_ok_in = rd_ok_ff;
      for (int i = 0; i < 28; i++) seq_in[i] = seq_ff[i];
      cmd_take = 1'b0;
      we = 1'b0; waddr = '0; wdata = '0; wbe = '0;
      rsp_valid = 1'b0;
      chpad_t = wp_ff + 1'b1 - cs_ff;
      chpad = 2'(3'd4 - {1'b0, chpad_t[1:0]});
      rspad = 2'(3'd4 - 3'(2'(9'd1 + {1'b0, cmd.text_length})));
      rneed = 9'd1 + {1'b0, cmd.text_length} + {7'd0, rspad};
      cur = base_ff + PW'(ix_ff);

      unique case (st_ff)
         rcpb_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               stat_in = rcpb_pkg::ST_OK;
               nb_in = '0; ix_in = '0; base_in = wp_ff;
               patch_in = 1'b0; patch2_in = 1'b0; rd_ok_in = 1'b0;
               st_in = rcpb_pkg::BK_WRITE;
               unique case (cmd.op)
                  rcpb_pkg::OP_RESET: begin
                     wp_in = '0; ps_in = '0; cs_in = '0; cnt_in = '0;
                     trem_in = '0; rpad_in = '0; trsn_in = 1'b0;
                  end
                  rcpb_pkg::OP_SR, rcpb_pkg::OP_RR: begin
                     if (space < ((cmd.op == rcpb_pkg::OP_SR) ? PW'(28) : PW'(8)))
                        stat_in = rcpb_pkg::ST_NO_SPACE;
                     else begin
                        ps_in = wp_ff; cnt_in = '0;
                        seq_in[0] = rcpb_pkg::HDR_BYTE;
                        seq_in[1] = (cmd.op == rcpb_pkg::OP_SR) ?
                                    rcpb_pkg::PT_SR : rcpb_pkg::PT_RR;
                        seq_in[2] = '0; seq_in[3] = '0;
                        {seq_in[4], seq_in[5], seq_in[6], seq_in[7]} = cmd.ssrc;
                        {seq_in[8], seq_in[9], seq_in[10], seq_in[11]} = cmd.v1;
                        {seq_in[12], seq_in[13], seq_in[14], seq_in[15]} = cmd.v2;
                        {seq_in[16], seq_in[17], seq_in[18], seq_in[19]} = cmd.v3;
                        {seq_in[20], seq_in[21], seq_in[22], seq_in[23]} = cmd.v4;
                        {seq_in[24], seq_in[25], seq_in[26], seq_in[27]} = cmd.v5;
                        nb_in = (cmd.op == rcpb_pkg::OP_SR) ? 5'd28 : 5'd8;
                     end
                  end
                  rcpb_pkg::OP_BLOCK, rcpb_pkg::OP_CHUNK, rcpb_pkg::OP_BYESSRC: begin
                     if (space < ((cmd.op == rcpb_pkg::OP_BLOCK) ? PW'(24) : PW'(4)))
                        stat_in = rcpb_pkg::ST_NO_SPACE;
                     else if (cnt_ff == 5'd31)
                        stat_in = rcpb_pkg::ST_FULL;
                     else begin
                        if (cmd.op == rcpb_pkg::OP_CHUNK) cs_in = wp_ff;
                        {seq_in[0], seq_in[1], seq_in[2], seq_in[3]} = cmd.ssrc;
                        seq_in[4] = cmd.fraction;
                        {seq_in[5], seq_in[6], seq_in[7]} = cmd.v1[23:0];
                        {seq_in[8], seq_in[9], seq_in[10], seq_in[11]} = cmd.v2;
                        {seq_in[12], seq_in[13], seq_in[14], seq_in[15]} = cmd.v3;
                        {seq_in[16], seq_in[17], seq_in[18], seq_in[19]} = cmd.v4;
                        {seq_in[20], seq_in[21], seq_in[22], seq_in[23]} = cmd.v5;
                        nb_in = (cmd.op == rcpb_pkg::OP_BLOCK) ? 5'd24 : 5'd4;
                        cnt_in = cnt_ff + 1'b1;
                        patch_in = 1'b1; paddr_in = ps_ff;
                        pdat_in = rcpb_pkg::HDR_BYTE | {3'd0, cnt_in};
                     end
                  end
                  rcpb_pkg::OP_SDES, rcpb_pkg::OP_BYE: begin
                     if (space < PW'(4)) stat_in = rcpb_pkg::ST_NO_SPACE;
                     else begin
                        ps_in = wp_ff; cnt_in = '0;
                        seq_in[0] = rcpb_pkg::HDR_BYTE;
                        seq_in[1] = (cmd.op == rcpb_pkg::OP_SDES) ?
                                    rcpb_pkg::PT_SDES : rcpb_pkg::PT_BYE;
                        seq_in[2] = '0; seq_in[3] = '0;
                        nb_in = 5'd4;
                     end
                  end
                  rcpb_pkg::OP_CNAME: begin
                     if (space < PW'({1'b0, cmd.text_length} + 9'd2))
                        stat_in = rcpb_pkg::ST_NO_SPACE;
                     else begin
                        seq_in[0] = rcpb_pkg::SDES_CNAME;
                        seq_in[1] = cmd.text_length;
                        nb_in = 5'd2;
                        trem_in = cmd.text_length; trsn_in = 1'b0; rpad_in = '0;
                     end
                  end
                  rcpb_pkg::OP_CHUNKEND: begin
                     if (space < PW'(3'd1 + {1'b0, chpad}))
                        stat_in = rcpb_pkg::ST_NO_SPACE;
                     else begin
                        for (int i = 0; i < 4; i++) seq_in[i] = '0;
                        nb_in = 5'(3'd1 + {1'b0, chpad});
                     end
                  end
                  rcpb_pkg::OP_REASON: begin
                     if (space < PW'(rneed)) stat_in = rcpb_pkg::ST_NO_SPACE;
                     else begin
                        for (int i = 0; i < 4; i++) seq_in[i] = '0;
                        seq_in[0] = cmd.text_length;
                        trem_in = cmd.text_length; trsn_in = 1'b1;
                        rpad_in = (cmd.text_length == '0) ? 2'd0 : rspad;
                        nb_in = (cmd.text_length == '0) ? 5'(3'd1 + {1'b0, rspad})
                                                        : 5'd1;
                     end
                  end
                  rcpb_pkg::OP_BYTE: begin
                     if (trem_ff != '0) begin
                        if (space < PW'((trem_ff == 8'd1 && trsn_ff) ?
                                        3'd1 + {1'b0, rpad_ff} : 3'd1))
                           stat_in = rcpb_pkg::ST_NO_SPACE;
                        else begin
                           for (int i = 0; i < 4; i++) seq_in[i] = '0;
                           seq_in[0] = cmd.text_byte;
                           trem_in = trem_ff - 1'b1;
                           if (trem_ff == 8'd1 && trsn_ff) begin
                              nb_in = 5'(3'd1 + {1'b0, rpad_ff});
                              rpad_in = '0;
                           end else nb_in = 5'd1;
                        end
                     end
                  end
                  rcpb_pkg::OP_END: begin
                     if (wp_ff < ps_ff || wp_ff == ps_ff || wp_ff[1:0] != ps_ff[1:0])
                        stat_in = rcpb_pkg::ST_MISALIGN;
                     else begin
                        // length word = bytes/4 - 1, written into bytes 2 and 3
                        patch_in = 1'b1; patch2_in = 1'b1;
                        paddr_in = ps_ff + PW'(2);
                        {pdat_in, pdat2_in} = 16'(((wp_ff - ps_ff) >> 2) - 1'b1);
                     end
                  end
                  rcpb_pkg::OP_READ: begin
                     ridx_in = cmd.read_index;
                     rd_ok_in = ({22'd0, cmd.read_index} < 32'(BUFFER_BYTES));
                     st_in = rcpb_pkg::BK_READ;
                  end
                  default: ;
               endcase
            end
         end
         rcpb_pkg::BK_WRITE: begin
            // one aligned word per cycle, then header patches
            if (ix_ff < nb_ff) begin
               we = (cur < PW'(BUFFER_BYTES));
               waddr = cur[AW-1:2];
               for (int b = 0; b < 4; b++) begin
                  if (cur[1:0] <= 2'(b) &&
                      (5'(ix_ff) + 5'(b) - 5'(cur[1:0])) < nb_ff) begin
                     wbe[3-b] = 1'b1;
                     wdata[8*(3-b) +: 8] = seq_ff[5'(ix_ff) + 5'(b) - 5'(cur[1:0])];
                  end
               end
               ix_in = ix_ff + 5'(3'd4 - {1'b0, cur[1:0]});
               if (ix_in > nb_ff) ix_in = nb_ff;
            end else if (patch_ff) begin
               // one header byte per cycle; the second may sit in the next word
               we = (paddr_ff < PW'(BUFFER_BYTES));
               waddr = paddr_ff[AW-1:2];
               wbe[2'd3 - paddr_ff[1:0]] = 1'b1;
               wdata[8*(3 - paddr_ff[1:0]) +: 8] = pdat_ff;
               if (patch2_ff) begin
                  paddr_in = paddr_ff + 1'b1;
                  pdat_in = pdat2_ff;
                  patch2_in = 1'b0;
               end else patch_in = 1'b0;
            end else begin
               wp_in = wp_ff + PW'(nb_ff);
               st_in = rcpb_pkg::BK_DONE;
            end
         end
         rcpb_pkg::BK_READ: st_in = rcpb_pkg::BK_DONE;
         rcpb_pkg::BK_DONE: begin
            rsp_valid = 1'b1;
            st_in = rcpb_pkg::BK_IDLE;
         end
         default: st_in = rcpb_pkg::BK_IDLE;
      endcase
   end

   assign rsp_status = stat_ff;
   assign rsp_message_length = 11'(wp_ff);
   assign rsp_read_data = rd_ok_ff ? rdat_ff : 8'd0;

   always_ff @(posedge clock) begin
      if (we) begin
         for (int b = 0; b < 4; b++)
            if (wbe[b]) mem[waddr][8*b +: 8] <= wdata[8*b +: 8];
      end
      rdat_ff <= mem[ridx_ff[AW-1:2]][8*(3 - ridx_ff[1:0]) +: 8];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 28; i++) seq_ff[i] <= seq_in[i];
      nb_ff <= nb_in; ix_ff <= ix_in; base_ff <= base_in;
      paddr_ff <= paddr_in; pdat_ff <= pdat_in; pdat2_ff <= pdat2_in;
      stat_ff <= stat_in; ridx_ff <= ridx_in;
      if (reset) begin
         st_ff <= rcpb_pkg::BK_IDLE;
         wp_ff <= '0; ps_ff <= '0; cs_ff <= '0; cnt_ff <= '0;
         trem_ff <= '0; rpad_ff <= '0; trsn_ff <= 1'b0;
         patch_ff <= 1'b0; patch2_ff <= 1'b0; rd_ok_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         wp_ff <= wp_in; ps_ff <= ps_in; cs_ff <= cs_in; cnt_ff <= cnt_in;
         trem_ff <= trem_in; rpad_ff <= rpad_in; trsn_ff <= trsn_in;
         patch_ff <= patch_in; patch2_ff <= patch2_in; rd_ok_ff <= rd_ok_in;
      end
   end
endmodule

// File: sv/rtcp_compound_packet_builder_core.sv
// RTCP compound packet builder, top level: command queue front end feeding the
// buffer-writing back end. Depends on rcpb_pkg, rcpb_front, rcpb_back.
// Flow: each command passes through the back end's idle, write (or read) and done states;
// the write state takes one step per buffer word touched and one per header byte patch.
// Throughput: one item per back-end pass; busy holds off items while the queue is full.
// Reset: synchronous, clears position, counters, text state; results strobe, no stall.
module rtcp_compound_packet_builder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_opcode,
   input  logic [31:0] req_ssrc,
   input  logic [7:0]  req_fraction,
   input  logic [31:0] req_value_1,
   input  logic [31:0] req_value_2,
   input  logic [31:0] req_value_3,
   input  logic [31:0] req_value_4,
   input  logic [31:0] req_value_5,
   input  logic [7:0]  req_text_length,
   input  logic [7:0]  req_text_byte,
   input  logic [9:0]  req_read_index,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [10:0] rsp_message_length,
   output logic [7:0]  rsp_read_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data
);
   rcpb_pkg::cmd_type in_cmd, head_cmd;
   logic q_full, q_empty, take;
   logic [10:0] limit_ff;

   // Pack the request ports into one item.
   always_comb begin
      in_cmd.op          = rcpb_pkg::opcode_type'(req_opcode);
      in_cmd.ssrc        = req_ssrc;
      in_cmd.fraction    = req_fraction;
      in_cmd.v1          = req_value_1;
      in_cmd.v2          = req_value_2;
      in_cmd.v3          = req_value_3;
      in_cmd.v4          = req_value_4;
      in_cmd.v5          = req_value_5;
      in_cmd.text_length = req_text_length;
      in_cmd.text_byte   = req_text_byte;
      in_cmd.read_index  = req_read_index;
   end

   // Hold off new items while the queue is full.
   assign busy = q_full;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= 11'd1024;
      else if (csr_valid) limit_ff <= csr_data;
   end

   rcpb_front u_front (
      .clock(clock), .reset(reset),
      .push(start && !q_full), .push_cmd(in_cmd), .full(q_full),
      .pop(take), .empty(q_empty), .head_cmd(head_cmd)
   );

   rcpb_back u_back (
      .clock(clock), .reset(reset), .limit(limit_ff),
      .cmd_valid(!q_empty), .cmd(head_cmd), .cmd_take(take),
      .rsp_valid(rsp_strobe), .rsp_status(rsp_status),
      .rsp_message_length(rsp_message_length), .rsp_read_data(rsp_read_data)
   );
endmodule
